// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/clcd_pkg.sv -----
// Types, codes and helpers for the character display nibble sequencer.
package clcd_pkg;

	localparam int unsigned DEFAULT_COLUMNS = 16;
	localparam int unsigned DEFAULT_ROWS    = 2;

	localparam int unsigned STEP_W = 5;

	typedef enum logic [2:0] {
		REQ_CHAR  = 3'd0,
		REQ_CMD   = 3'd1,
		REQ_CLEAR = 3'd2,
		REQ_HOME  = 3'd3,
		REQ_GOTO  = 3'd4,
		REQ_INIT  = 3'd5,
		REQ_GLYPH = 3'd6
	} req_kind_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  data_byte;
		logic [7:0]  target_col;
		logic [7:0]  target_row;
		logic [63:0] glyph_rows;
	} req_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  bus_nibble;
		logic [17:0] wait_before_us;
		logic [11:0] wait_after_us;
		logic [7:0]  cursor_col;
		logic [1:0]  cursor_row;
		logic        last_transfer;
	} xfer_t;

	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_CGRAM    = 8'h40;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;
	localparam logic [7:0] LINE1_BASE   = 8'h40;

	localparam logic [11:0] WAIT_BYTE_US  = 12'd50;
	localparam logic [11:0] WAIT_CLEAR_US = 12'd2050;

	localparam logic [17:0] INIT_WAIT0_US = 18'd20000;
	localparam logic [17:0] INIT_WAIT1_US = 18'd5000;
	localparam logic [17:0] INIT_WAIT2_US = 18'd150;
	localparam logic [17:0] INIT_WAIT3_US = 18'd150000;

	localparam logic [3:0] INIT_NIB_WAKE = 4'h3;
	localparam logic [3:0] INIT_NIB_4BIT = 4'h2;

	localparam logic [STEP_W-1:0] LAST_STEP_BYTE  = 5'd1;
	localparam logic [STEP_W-1:0] LAST_STEP_INIT  = 5'd7;
	localparam logic [STEP_W-1:0] LAST_STEP_GLYPH = 5'd19;

	// Remainder of an 8-bit value by a constant divisor of at most 64.
	// recip is ceil(2**16 / d), which makes the quotient exact for any 8-bit value.
	function automatic logic [7:0] mod_const(input logic [7:0] v, input logic [7:0] d,
			input logic [16:0] recip);
		logic [24:0] prod;
		logic [7:0]  quo;
		logic [15:0] back;
		prod = {17'd0, v} * {8'd0, recip};
		quo  = prod[23:16];
		back = {8'd0, quo} * {8'd0, d};
		return v - back[7:0];
	endfunction

endpackage

// ----- design/char_lcd_nibble_sequencer.sv -----
// Top level: 4-bit character display sequencer, request in, bus transfers out.
// A request is held in one register while its bus transfers leave one per cycle
// through an output register whenever the output side takes them: 2 transfers for
// a character, raw command, clear, home or goto, 8 for init and 20 for a glyph
// load. The next request is taken in the cycle in which the last transfer of
// the current one moves to the output register, so requests follow each other
// without a gap. A request of the unused type 7 is taken and dropped with no
// transfers and no change to the cursor. The cursor column and row are tracked
// here and reported, as they stand after the request, on every transfer of it.
module char_lcd_nibble_sequencer #(
	parameter int unsigned COLUMNS = clcd_pkg::DEFAULT_COLUMNS,
	parameter int unsigned ROWS    = clcd_pkg::DEFAULT_ROWS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  clcd_pkg::req_t  req,
	output logic            xfer_valid,
	input  logic            xfer_ready,
	output clcd_pkg::xfer_t xfer
);
	import clcd_pkg::*;

	req_t              req_s1;
	logic              valid_s1;
	logic [STEP_W-1:0] step_s1;
	logic [7:0]        col_q;
	logic [1:0]        row_q;
	xfer_t             xfer_q;
	logic              xfer_valid_q;
	xfer_t             gen_xfer;
	logic              issue;
	logic              issue_last;
	logic              accept;

	clcd_xfer_gen #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_xfer_gen (
		.req    (req_s1),
		.step   (step_s1),
		.cur_col(col_q),
		.cur_row(row_q),
		.xfer   (gen_xfer)
	);

	assign issue      = valid_s1 && (!xfer_valid_q || xfer_ready);
	assign issue_last = issue && gen_xfer.last_transfer;
	assign req_ready  = !valid_s1 || issue_last;
	assign accept     = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			step_s1      <= '0;
			col_q        <= 8'd0;
			row_q        <= 2'd0;
			xfer_valid_q <= 1'b0;
		end else begin
			// drop requests of the unused type at the door
			if (accept) begin
				valid_s1 <= (req.req_type <= REQ_GLYPH);
				step_s1  <= '0;
			end else if (issue_last) begin
				valid_s1 <= 1'b0;
			end else if (issue) begin
				step_s1 <= step_s1 + 5'd1;
			end
			// commit the cursor once the request has fully gone out
			if (issue_last) begin
				col_q <= gen_xfer.cursor_col;
				row_q <= gen_xfer.cursor_row;
			end
			if (issue) begin
				xfer_valid_q <= 1'b1;
			end else if (xfer_ready) begin
				xfer_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (issue) begin
			xfer_q <= gen_xfer;
		end
	end

	assign xfer_valid = xfer_valid_q;
	assign xfer       = xfer_q;

endmodule

// ----- design/clcd_xfer_gen.sv -----
// Transfer generator: one bus transfer of a request, chosen by its step number.
module clcd_xfer_gen #(
	parameter int unsigned COLUMNS = clcd_pkg::DEFAULT_COLUMNS,
	parameter int unsigned ROWS    = clcd_pkg::DEFAULT_ROWS
) (
	input  clcd_pkg::req_t                   req,
	input  logic [clcd_pkg::STEP_W-1:0]      step,
	input  logic [7:0]                       cur_col,
	input  logic [1:0]                       cur_row,
	output clcd_pkg::xfer_t                  xfer
);
	import clcd_pkg::*;

	localparam logic [7:0] COL_C = 8'(COLUMNS);
	localparam logic [7:0] ROW_C = 8'(ROWS);
	localparam logic [16:0] COL_RECIP = 17'((32'd65536 + COLUMNS - 32'd1) / COLUMNS);
	localparam logic [16:0] ROW_RECIP = 17'((32'd65536 + ROWS - 32'd1) / ROWS);

	logic [7:0]  src_col;
	logic [7:0]  src_row;
	logic [7:0]  goto_col;
	logic [1:0]  goto_row;
	logic [7:0]  row_mod;
	logic [7:0]  line_base;
	logic [7:0]  goto_byte;
	logic [3:0]  byte_idx;
	logic        low_half;
	logic [2:0]  gsel;
	logic [7:0]  cur_byte;
	logic        long_wait;
	logic        nib_mode;
	logic [3:0]  raw_nib;
	logic [17:0] before_us;
	logic [STEP_W-1:0] last_step;

	assign byte_idx = step[STEP_W-1:1];
	assign low_half = step[0];
	assign gsel     = 3'(byte_idx - 4'd1);

	// Goto takes the requested position; glyph load returns to the held one.
	always_comb begin
		if (req.req_type == REQ_GOTO) begin
			src_col = req.target_col;
			src_row = req.target_row;
		end else begin
			src_col = cur_col;
			src_row = {6'd0, cur_row};
		end
		goto_col = mod_const(src_col, COL_C, COL_RECIP);
		row_mod  = mod_const(src_row, ROW_C, ROW_RECIP);
		goto_row = row_mod[1:0];
		case (goto_row)
			2'd0:    line_base = 8'h00;
			2'd1:    line_base = LINE1_BASE;
			2'd2:    line_base = COL_C;
			default: line_base = 8'(LINE1_BASE + COL_C);
		endcase
		goto_byte = CMD_DDRAM | 8'(goto_col + line_base);
	end

	always_comb begin
		xfer            = '0;
		cur_byte        = 8'h00;
		long_wait       = 1'b0;
		nib_mode        = 1'b0;
		raw_nib         = 4'h0;
		before_us       = '0;
		last_step       = LAST_STEP_BYTE;
		xfer.cursor_col = cur_col;
		xfer.cursor_row = cur_row;
		case (req.req_type)
			REQ_CHAR: begin
				xfer.reg_select = 1'b1;
				cur_byte        = req.data_byte;
				xfer.cursor_col = 8'(cur_col + 8'd1);
			end
			REQ_CMD: begin
				cur_byte = req.data_byte;
			end
			REQ_CLEAR, REQ_HOME: begin
				cur_byte        = (req.req_type == REQ_CLEAR) ? CMD_CLEAR : CMD_HOME;
				long_wait       = 1'b1;
				xfer.cursor_col = 8'd0;
				xfer.cursor_row = 2'd0;
			end
			REQ_GOTO: begin
				cur_byte        = goto_byte;
				xfer.cursor_col = goto_col;
				xfer.cursor_row = goto_row;
			end
			REQ_INIT: begin
				last_step = LAST_STEP_INIT;
				if (step < 5'd4) begin
					nib_mode = 1'b1;
					raw_nib  = (step == 5'd3) ? INIT_NIB_4BIT : INIT_NIB_WAKE;
					case (step[1:0])
						2'd0:    before_us = INIT_WAIT0_US;
						2'd1:    before_us = INIT_WAIT1_US;
						2'd2:    before_us = INIT_WAIT2_US;
						default: before_us = INIT_WAIT3_US;
					endcase
				end else begin
					cur_byte = step[1] ? CMD_DISP_ON : CMD_FUNC_SET;
				end
			end
			REQ_GLYPH: begin
				last_step       = LAST_STEP_GLYPH;
				xfer.cursor_col = goto_col;
				xfer.cursor_row = goto_row;
				if (byte_idx == 4'd0) begin
					cur_byte = CMD_CGRAM | {2'b00, req.data_byte[2:0], 3'b000};
				end else if (byte_idx == 4'd9) begin
					cur_byte = goto_byte;
				end else begin
					xfer.reg_select = 1'b1;
					cur_byte        = req.glyph_rows[{gsel, 3'b000} +: 8];
				end
			end
			default: begin
				last_step = LAST_STEP_BYTE;
			end
		endcase

		if (nib_mode) begin
			xfer.bus_nibble     = raw_nib;
			xfer.wait_before_us = before_us;
			xfer.wait_after_us  = 12'd0;
		end else begin
			xfer.bus_nibble     = low_half ? cur_byte[3:0] : cur_byte[7:4];
			xfer.wait_before_us = 18'd0;
			if (low_half) begin
				xfer.wait_after_us = long_wait ? WAIT_CLEAR_US : WAIT_BYTE_US;
			end else begin
				xfer.wait_after_us = 12'd0;
			end
		end
		xfer.last_transfer = (step == last_step);
	end

endmodule

// ----- design/clcd_checker.sv -----
// Port-level checker for the nibble sequencer, bound to the top level.
`include "assert_macros.svh"

module clcd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input clcd_pkg::req_t  req,
	input logic            xfer_valid,
	input logic            xfer_ready,
	input clcd_pkg::xfer_t xfer
);
	import clcd_pkg::*;

	logic       prev_last_q;
	logic [7:0] prev_col_q;
	logic [1:0] prev_row_q;
	logic       xfer_done;
	logic       cursor_same;
	logic       cursor_home;
	logic       init_shown;
	logic       init_ok;
	logic       long_shown;
	logic       long_ok;

	assign xfer_done   = xfer_valid && xfer_ready;
	assign cursor_same = (xfer.cursor_col == prev_col_q) && (xfer.cursor_row == prev_row_q);
	assign cursor_home = (xfer.cursor_col == 8'd0) && (xfer.cursor_row == 2'd0);
	assign init_shown  = xfer_valid && (xfer.wait_before_us != 18'd0);
	assign init_ok     = !xfer.reg_select && (xfer.wait_after_us == 12'd0);
	assign long_shown  = xfer_valid && (xfer.wait_after_us == WAIT_CLEAR_US);
	assign long_ok     = xfer.last_transfer && !xfer.reg_select && cursor_home;

	// track the cursor reported within one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
			prev_col_q  <= 8'd0;
			prev_row_q  <= 2'd0;
		end else if (xfer_done) begin
			prev_last_q <= xfer.last_transfer;
			prev_col_q  <= xfer.cursor_col;
			prev_row_q  <= xfer.cursor_row;
		end
	end

	`ASSERT_NEXT(a_xfer_hold, xfer_valid && !xfer_ready, xfer_valid && $stable(xfer))
	`ASSERT_IMPL(a_cursor_steady, xfer_done && !prev_last_q, cursor_same)
	`ASSERT_IMPL(a_init_wait, init_shown, init_ok)
	`ASSERT_IMPL(a_long_wait, long_shown, long_ok)

endmodule

bind char_lcd_nibble_sequencer clcd_checker u_clcd_checker (.*);
